// ----- rtl/core/vcfc_pkg.sv -----
`default_nettype none
package vcfc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CMP_W      = 11;
    localparam int NUM_DIRS   = 6;
    localparam int DIR_W      = 3;
    localparam int NB_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd2;

    localparam logic [NB_W-1:0] NB_POS_X = 2'd0;
    localparam logic [NB_W-1:0] NB_POS_Y = 2'd1;
    localparam logic [NB_W-1:0] NB_NEG_X = 2'd2;
    localparam logic [NB_W-1:0] NB_NEG_Y = 2'd3;

    localparam logic [0:0] CMD_WRITE  = 1'b0;
    localparam logic [0:0] CMD_COLUMN = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CENTER,
        S_NB,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/vcfc_ram.sv -----
`default_nettype none
module vcfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/core/voxel_column_face_culler_unit.sv -----
`default_nettype none
// Voxel column face culler. A write item (command 0) stores one RGBA pixel and
// leaves the unit free for the next item. A column item (command 1) reads the column's own
// pixel and then its four side neighbours from the single pixel memory, one read per cycle,
// and then emits one visible face per cycle on o_strobe, with o_last_face on the final one.
// A column item keeps busy high until its last face and emits at most 62 faces;
// a transparent column ends once its pixel is read, and a column outside the configured image
// or with zero layers is done in its accept cycle. Faces cannot be held off by the receiver.
// Configuration writes are always taken and must only be made while busy is low.
module voxel_column_face_culler_unit
    import vcfc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_LAYERS = 15
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_command,
    input  wire logic [5:0]            i_pos_x,
    input  wire logic [5:0]            i_pos_y,
    input  wire logic [31:0]           i_pixel_rgba,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output logic [5:0]                 o_face_x,
    output logic [5:0]                 o_face_y,
    output logic [3:0]                 o_face_z,
    output logic [2:0]                 o_face_dir,
    output logic [31:0]                o_face_color,
    output logic                       o_last_face
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAXH_C = CMP_W'(MAX_HEIGHT);
    localparam logic [3:0]       MAXL_C = 4'(MAX_LAYERS);

    t_state r_state, n_state;

    logic [6:0]          r_image_width;
    logic [6:0]          r_image_height;
    logic [3:0]          r_block_height;
    logic [5:0]          r_x, n_x;
    logic [5:0]          r_y, n_y;
    logic [31:0]         r_color, n_color;
    logic [3:0]          r_side, n_side;
    logic [NB_W-1:0]     r_nb, n_nb;
    logic [3:0]          r_z, n_z;
    logic [NUM_DIRS-1:0] r_pend, n_pend;

    logic [CMP_W-1:0] eff_w, eff_h;
    logic [3:0]       eff_l;
    logic             accept, col_ok, wr_ok;
    logic [CMP_W-1:0] in_x, in_y, cur_x, cur_y;
    logic [3:0]       oob;
    logic [NB_W-1:0]  rd_dir;
    logic [CMP_W-1:0] nb_x, nb_y;
    logic [31:0]      addr_nb, addr_in;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;
    logic             rd_opaque;
    logic [DIR_W-1:0] sel_dir;
    logic [NUM_DIRS-1:0] rest;
    logic             top_z;

    assign eff_w = (CMP_W'(r_image_width) < MAXW_C) ? CMP_W'(r_image_width) : MAXW_C;
    assign eff_h = (CMP_W'(r_image_height) < MAXH_C) ? CMP_W'(r_image_height) : MAXH_C;
    assign eff_l = (r_block_height < MAXL_C) ? r_block_height : MAXL_C;

    assign accept  = start && !busy;
    assign in_x    = CMP_W'(i_pos_x);
    assign in_y    = CMP_W'(i_pos_y);
    assign cur_x   = CMP_W'(r_x);
    assign cur_y   = CMP_W'(r_y);
    assign col_ok  = (eff_l != 4'd0) && (in_x < eff_w) && (in_y < eff_h);
    assign wr_ok   = (in_x < MAXW_C) && (in_y < MAXH_C);
    assign addr_in = 32'(in_y) * 32'(MAX_WIDTH) + 32'(in_x);

    assign oob[NB_POS_X] = (cur_x + CMP_W'(1)) >= eff_w;
    assign oob[NB_POS_Y] = (cur_y + CMP_W'(1)) >= eff_h;
    assign oob[NB_NEG_X] = (r_x == 6'd0);
    assign oob[NB_NEG_Y] = (r_y == 6'd0);

    // neighbour address; out-of-image reads wrap and are ignored
    assign rd_dir = (r_state == S_CENTER) ? NB_POS_X : r_nb + NB_W'(1);
    always_comb begin
        nb_x = cur_x;
        nb_y = cur_y;
        case (rd_dir)
            NB_POS_X: nb_x = cur_x + CMP_W'(1);
            NB_POS_Y: nb_y = cur_y + CMP_W'(1);
            NB_NEG_X: nb_x = cur_x - CMP_W'(1);
            NB_NEG_Y: nb_y = cur_y - CMP_W'(1);
            default:  nb_x = cur_x;
        endcase
    end
    assign addr_nb = 32'(nb_y) * 32'(MAX_WIDTH) + 32'(nb_x);

    assign rd_opaque = (ram_rdata[31:24] != 8'd0);

    vcfc_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pixels (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr_in[AW-1:0]),
        .i_wdata (i_pixel_rgba),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lowest pending direction of the current layer
    always_comb begin
        sel_dir = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel_dir = DIR_W'(i);
            end
        end
    end
    assign rest  = r_pend & ~(NUM_DIRS'(1) << sel_dir);
    assign top_z = (r_z == eff_l - 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_command == CMD_COLUMN && col_ok) begin
                    n_state = S_CENTER;
                end
            end
            S_CENTER: begin
                n_state = rd_opaque ? S_NB : S_IDLE;
            end
            S_NB: begin
                if (r_nb == NB_NEG_Y) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (rest == '0 && top_z) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_color   = r_color;
        n_side    = r_side;
        n_nb      = r_nb;
        n_z       = r_z;
        n_pend    = r_pend;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = addr_nb[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_x = i_pos_x;
                n_y = i_pos_y;
                if (accept && i_command == CMD_WRITE && wr_ok) begin
                    ram_we = 1'b1;
                end
                if (accept && i_command == CMD_COLUMN && col_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_in[AW-1:0];
                end
            end
            S_CENTER: begin
                n_color = ram_rdata;
                n_nb    = NB_POS_X;
                ram_re  = rd_opaque;
            end
            S_NB: begin
                n_side[r_nb] = oob[r_nb] || !rd_opaque;
                if (r_nb == NB_NEG_Y) begin
                    n_z    = 4'd0;
                    n_pend = {1'b1, eff_l == 4'd1, n_side};
                end else begin
                    n_nb   = r_nb + NB_W'(1);
                    ram_re = 1'b1;
                end
            end
            S_EMIT: begin
                if (rest == '0) begin
                    if (r_side == '0) begin
                        // no side faces, so only the top layer has more to show
                        n_z    = eff_l - 4'd1;
                        n_pend = {2'b01, r_side};
                    end else begin
                        n_z    = r_z + 4'd1;
                        n_pend = {1'b0, (r_z + 4'd1) == eff_l - 4'd1, r_side};
                    end
                end else begin
                    n_pend = rest;
                end
            end
            default: n_nb = r_nb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_image_width  <= 7'd64;
            r_image_height <= 7'd64;
            r_block_height <= 4'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    CFG_BLOCK_HEIGHT: r_block_height <= i_cfg_data[3:0];
                    default:          r_block_height <= r_block_height;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_color <= n_color;
        r_side  <= n_side;
        r_nb    <= n_nb;
        r_z     <= n_z;
        r_pend  <= n_pend;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = (r_state == S_EMIT);
    assign o_face_x     = r_x;
    assign o_face_y     = r_y;
    assign o_face_z     = r_z;
    assign o_face_dir   = sel_dir;
    assign o_face_color = r_color;
    assign o_last_face  = o_strobe && (rest == '0) && top_z;

    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pend != '0))
        else $error("emit with no pending face");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_face) |=> !busy)
        else $error("unit still busy after last face");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_WRITE) |=> !busy)
        else $error("write item kept unit busy");

    a_face_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_face_color[31:24] != 8'd0))
        else $error("face emitted for transparent column");

endmodule
`default_nettype wire
